// ===== rtl/core/apt_pkg.sv =====
// Package for the affine point transform: matrix shape, widths, op codes,
// saturation limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 4;
  localparam int ROWS            = 3;
  localparam int COLS            = 4;
  localparam int ROW_W           = 2;
  localparam int COL_W           = 2;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/core/apt_front.sv =====
// Front end: accepts items, holds the 3x4 coefficient matrix, applies loads
// and forms the nine scaled products of a transform. Depends on apt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apt_front #(
  parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF,
  localparam int PW = 2 * apt_pkg::DATA_W - FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_operation,
  input  logic [apt_pkg::IDX_W-1:0]              in_coeff_index,
  input  logic signed [apt_pkg::DATA_W-1:0]      in_coeff_value,
  input  logic signed [apt_pkg::DATA_W-1:0]      in_point_x,
  input  logic signed [apt_pkg::DATA_W-1:0]      in_point_y,
  input  logic signed [apt_pkg::DATA_W-1:0]      in_point_z,
  output logic                                   t_valid,
  input  logic                                   t_ready,
  output logic [apt_pkg::ROWS-1:0][apt_pkg::COLS-1:0][PW-1:0] t_data
);

  localparam logic [apt_pkg::DATA_W-1:0] ONE_FX =
    apt_pkg::DATA_W'(64'd1 << FRAC_BITS);

  logic signed [apt_pkg::DATA_W-1:0] coef_r [apt_pkg::ROWS][apt_pkg::COLS];
  logic [apt_pkg::ROWS-1:0][apt_pkg::COLS-1:0][PW-1:0] data_r, data_nxt;
  logic valid_r, valid_nxt;
  logic signed [apt_pkg::DATA_W-1:0] pt [apt_pkg::COLS-1];
  logic accept, load_hit, xform_acc;
  logic [apt_pkg::ROW_W-1:0] wr_row;
  logic [apt_pkg::COL_W-1:0] wr_col;

  assign in_ready  = !valid_r || t_ready;
  assign accept    = in_valid && in_ready;
  assign load_hit  = accept && (in_operation == apt_pkg::OP_LOAD) &&
                     (in_coeff_index < apt_pkg::IDX_W'(apt_pkg::ROWS * apt_pkg::COLS));
  assign xform_acc = accept && (in_operation == apt_pkg::OP_XFORM);
  assign wr_row    = in_coeff_index[apt_pkg::IDX_W-1 -: apt_pkg::ROW_W];
  assign wr_col    = in_coeff_index[apt_pkg::COL_W-1:0];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    logic signed [2*apt_pkg::DATA_W-1:0] prod;
    prod = '0;
    for (int r = 0; r < apt_pkg::ROWS; r++) begin
      for (int c = 0; c < apt_pkg::COLS - 1; c++) begin
        prod = pt[c] * coef_r[r][c];
        data_nxt[r][c] = prod[2*apt_pkg::DATA_W-1:FRAC_BITS];
      end
      data_nxt[r][apt_pkg::COLS-1] = PW'(coef_r[r][apt_pkg::COLS-1]);
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = xform_acc;
    end else if (t_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int r = 0; r < apt_pkg::ROWS; r++) begin
        for (int c = 0; c < apt_pkg::COLS; c++) begin
          coef_r[r][c] <= (r == c) ? ONE_FX : '0;
        end
      end
    end else begin
      valid_r <= valid_nxt;
      if (load_hit) begin
        coef_r[wr_row][wr_col] <= in_coeff_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xform_acc) begin
      data_r <= data_nxt;
    end
  end

  assign t_valid = valid_r;
  assign t_data  = data_r;

`ifndef SYNTHESIS
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    load_hit |=> coef_r[$past(wr_row)][$past(wr_col)] == $past(in_coeff_value))
    else $error("coefficient load not stored");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/apt_queue.sv =====
// Short FIFO between front and back end; register storage, one push and
// one pop per cycle unless full or empty. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module apt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign in_ready  = cnt_r < CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/apt_back.sv =====
// Back end: sums the row terms, saturates to 32 bits and holds the result
// in the output register. Depends on apt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apt_back #(
  parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF,
  localparam int PW = 2 * apt_pkg::DATA_W - FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [apt_pkg::ROWS-1:0][apt_pkg::COLS-1:0][PW-1:0] in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [apt_pkg::DATA_W-1:0]      out_x,
  output logic signed [apt_pkg::DATA_W-1:0]      out_y,
  output logic signed [apt_pkg::DATA_W-1:0]      out_z,
  output logic                                   out_overflow
);

  localparam int SW = PW + 2;
  localparam int HW = SW - apt_pkg::DATA_W + 1;

  logic signed [apt_pkg::DATA_W-1:0] res_r [apt_pkg::ROWS];
  logic signed [apt_pkg::DATA_W-1:0] res_nxt [apt_pkg::ROWS];
  logic ovf_r, ovf_nxt;
  logic valid_r;
  logic pop;

  assign in_ready = !valid_r || out_ready;
  assign pop      = in_valid && in_ready;

  always_comb begin
    logic signed [SW-1:0] sum;
    logic [HW-1:0]        hi;
    ovf_nxt = 1'b0;
    sum     = '0;
    hi      = '0;
    for (int r = 0; r < apt_pkg::ROWS; r++) begin
      sum = '0;
      for (int c = 0; c < apt_pkg::COLS; c++) begin
        sum = sum + SW'($signed(in_data[r][c]));
      end
      hi = sum[SW-1:apt_pkg::DATA_W-1];
      if (hi == '0 || hi == '1) begin
        res_nxt[r] = sum[apt_pkg::DATA_W-1:0];
      end else begin
        ovf_nxt    = 1'b1;
        res_nxt[r] = sum[SW-1] ? apt_pkg::SAT_MIN : apt_pkg::SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int r = 0; r < apt_pkg::ROWS; r++) begin
        res_r[r] <= res_nxt[r];
      end
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_x        = res_r[0];
  assign out_y        = res_r[1];
  assign out_z        = res_r[2];
  assign out_overflow = ovf_r;

`ifndef SYNTHESIS
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_x == apt_pkg::SAT_MAX || out_x == apt_pkg::SAT_MIN ||
       out_y == apt_pkg::SAT_MAX || out_y == apt_pkg::SAT_MIN ||
       out_z == apt_pkg::SAT_MAX || out_z == apt_pkg::SAT_MIN))
    else $error("overflow flagged without a saturated output");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/affine_point_transform.sv =====
// Top level of the affine point transform: front end, queue, back end.
// Depends on apt_pkg, apt_front, apt_queue, apt_back.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   operation, coeff_index, coeff_value, point_x/y/z
//   out_     output     out_valid / out_ready out_x, out_y, out_z, out_overflow
//
// One item per clock while in_ready is high. A transform result passes these
// registers in order: the nine products are registered at the accepting edge,
// the queue stores them, and the row sums and saturation land in the output
// register, where the result is shown. Loads take effect for the next item and
// give no result. Reset loads the identity matrix at once. With the output stalled,
// four transforms are held (front, two in the queue, back) before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_transform #(
  parameter int FRAC_BITS   = apt_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = apt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [apt_pkg::IDX_W-1:0]         in_coeff_index,
  input  logic signed [apt_pkg::DATA_W-1:0] in_coeff_value,
  input  logic signed [apt_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [apt_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [apt_pkg::DATA_W-1:0] in_point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [apt_pkg::DATA_W-1:0] out_x,
  output logic signed [apt_pkg::DATA_W-1:0] out_y,
  output logic signed [apt_pkg::DATA_W-1:0] out_z,
  output logic                              out_overflow
);

  localparam int PW = 2 * apt_pkg::DATA_W - FRAC_BITS;
  localparam int EW = apt_pkg::ROWS * apt_pkg::COLS * PW;

  logic f_valid, f_ready;
  logic b_valid, b_ready;
  logic [apt_pkg::ROWS-1:0][apt_pkg::COLS-1:0][PW-1:0] f_data, b_data;
  logic [EW-1:0] q_in, q_out;

  apt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .t_valid        (f_valid),
    .t_ready        (f_ready),
    .t_data         (f_data)
  );

  assign q_in   = f_data;
  assign b_data = q_out;

  apt_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (q_out)
  );

  apt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (b_valid),
    .in_ready     (b_ready),
    .in_data      (b_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_overflow (out_overflow)
  );

endmodule

`default_nettype wire
